FILE: rtl/core/keyed_count_deque_assert.svh
// Assertion macros for the keyed count deque.
`ifndef KEYED_COUNT_DEQUE_ASSERT_SVH
`define KEYED_COUNT_DEQUE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define KCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define KCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define KCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/core/kcd_pkg.sv
// Types and constants shared by the keyed count deque.
package kcd_pkg;

    localparam int KEY_W = 16;
    localparam int QTY_W = 16;
    localparam int ENTRY_W = KEY_W + QTY_W;

    localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;
    localparam logic [2:0] CMD_STATUS     = 3'd4;

    localparam logic [31:0] SUM_MAX   = 32'd4194303;
    localparam logic [31:0] COUNT_MAX = 32'd127;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [QTY_W-1:0] quantity;
    } entry_t;

endpackage

FILE: rtl/core/kcd_ram.sv
// Generic simple dual-port RAM with registered read.
module kcd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/keyed_count_deque.sv
// Keyed count deque: bounded double-ended queue with sum and top-quantity key.
// An accepted command passes through the scan state, reading the N entries held after the step,
// then the out state, where done pulses; a new command is taken only when busy is low. The scan
// reads one slot per cycle through the single read port of the entry RAM.
// Reset clears pointers, count and sum at once; the entry RAM is not cleared and needs no pass.
// Results cannot be stalled: done is high for a single cycle, and the results stay on the ports until the next accept.
`include "keyed_count_deque_assert.svh"

module keyed_count_deque #(
    parameter int DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  command,
    input  logic [15:0] new_key,
    input  logic [15:0] new_quantity,
    output logic        done,
    output logic [15:0] popped_key,
    output logic [15:0] popped_quantity,
    output logic        empty_error,
    output logic        full_error,
    output logic [6:0]  entry_total,
    output logic [21:0] quantity_sum,
    output logic [15:0] top_key,
    output logic        top_valid
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = kcd_pkg::QTY_W + CW;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    logic [SW-1:0] sum_reg, sum_next;
    logic [CW-1:0] scan_idx_reg, scan_idx_next;
    logic          pop_rd_reg, pop_rd_next;
    logic          cmp_rd_reg, cmp_rd_next;
    logic          cmp_first_reg, cmp_first_next;
    logic          empty_err_reg, empty_err_next;
    logic          full_err_reg, full_err_next;
    logic [15:0]   popped_key_reg, popped_key_next;
    logic [15:0]   popped_qty_reg, popped_qty_next;
    logic [15:0]   best_key_reg, best_key_next;
    logic [15:0]   best_qty_reg, best_qty_next;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [AW-1:0]   ram_raddr;
    kcd_pkg::entry_t ram_wentry;
    kcd_pkg::entry_t ram_rentry;
    logic [kcd_pkg::ENTRY_W-1:0] ram_rdata;

    logic          is_push;
    logic          is_pop;
    logic [AW-1:0] front_dec;
    logic [AW-1:0] front_inc;
    logic [31:0]   sum_wide;
    logic [31:0]   count_wide;

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(off);
        if (s >= (CW+1)'(DEPTH))
        begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    kcd_ram #(
        .WIDTH (kcd_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_rentry = kcd_pkg::entry_t'(ram_rdata);
    assign ram_wentry = '{key: new_key, quantity: new_quantity};

    assign is_push = (command == kcd_pkg::CMD_PUSH_BACK) || (command == kcd_pkg::CMD_PUSH_FRONT);
    assign is_pop  = (command == kcd_pkg::CMD_POP_FRONT) || (command == kcd_pkg::CMD_POP_BACK);
    assign front_dec = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == AW'(DEPTH - 1)) ? '0 : front_reg + 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        scan_idx_next   = scan_idx_reg;
        pop_rd_next     = pop_rd_reg;
        cmp_rd_next     = cmp_rd_reg;
        cmp_first_next  = cmp_first_reg;
        empty_err_next  = empty_err_reg;
        full_err_next   = full_err_reg;
        popped_key_next = popped_key_reg;
        popped_qty_next = popped_qty_reg;
        best_key_next   = best_key_reg;
        best_qty_next   = best_qty_reg;
        ram_we          = 1'b0;
        ram_waddr       = slot_of(front_reg, count_reg);
        ram_raddr       = front_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    empty_err_next  = 1'b0;
                    full_err_next   = 1'b0;
                    popped_key_next = '0;
                    popped_qty_next = '0;
                    pop_rd_next     = 1'b0;
                    cmp_rd_next     = 1'b0;
                    scan_idx_next   = '0;
                    state_next      = ST_SCAN;
                    if (is_push)
                    begin
                        if (count_reg == CW'(DEPTH))
                        begin
                            full_err_next = 1'b1;
                        end
                        else
                        begin
                            ram_we = 1'b1;
                            if (command == kcd_pkg::CMD_PUSH_FRONT)
                            begin
                                front_next = front_dec;
                                ram_waddr  = front_dec;
                            end
                            count_next = count_reg + 1'b1;
                            sum_next   = sum_reg + SW'(new_quantity);
                        end
                    end
                    else if (is_pop)
                    begin
                        if (count_reg == '0)
                        begin
                            empty_err_next = 1'b1;
                        end
                        else
                        begin
                            if (command == kcd_pkg::CMD_POP_FRONT)
                            begin
                                ram_raddr  = front_reg;
                                front_next = front_inc;
                            end
                            else
                            begin
                                ram_raddr = slot_of(front_reg, count_reg - 1'b1);
                            end
                            count_next  = count_reg - 1'b1;
                            pop_rd_next = 1'b1;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                // The popped entry lands as the scan state opens, ahead of all scan data.
                if (pop_rd_reg)
                begin
                    popped_key_next = ram_rentry.key;
                    popped_qty_next = ram_rentry.quantity;
                    sum_next        = sum_reg - SW'(ram_rentry.quantity);
                    pop_rd_next     = 1'b0;
                end
                if (cmp_rd_reg && (cmp_first_reg || (ram_rentry.quantity > best_qty_reg)))
                begin
                    best_key_next = ram_rentry.key;
                    best_qty_next = ram_rentry.quantity;
                end
                if (scan_idx_reg != count_reg)
                begin
                    ram_raddr      = slot_of(front_reg, scan_idx_reg);
                    cmp_rd_next    = 1'b1;
                    cmp_first_next = (scan_idx_reg == '0);
                    scan_idx_next  = scan_idx_reg + 1'b1;
                end
                else
                begin
                    cmp_rd_next = 1'b0;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            scan_idx_reg  <= '0;
            pop_rd_reg    <= 1'b0;
            cmp_rd_reg    <= 1'b0;
            cmp_first_reg <= 1'b0;
            empty_err_reg <= 1'b0;
            full_err_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            scan_idx_reg  <= scan_idx_next;
            pop_rd_reg    <= pop_rd_next;
            cmp_rd_reg    <= cmp_rd_next;
            cmp_first_reg <= cmp_first_next;
            empty_err_reg <= empty_err_next;
            full_err_reg  <= full_err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        popped_key_reg <= popped_key_next;
        popped_qty_reg <= popped_qty_next;
        best_key_reg   <= best_key_next;
        best_qty_reg   <= best_qty_next;
    end

    assign sum_wide   = 32'(sum_reg);
    assign count_wide = 32'(count_reg);

    assign busy            = (state_reg != ST_IDLE);
    assign done            = (state_reg == ST_OUT);
    assign popped_key      = popped_key_reg;
    assign popped_quantity = popped_qty_reg;
    assign empty_error     = empty_err_reg;
    assign full_error      = full_err_reg;
    assign entry_total     = (count_wide > kcd_pkg::COUNT_MAX) ? 7'(kcd_pkg::COUNT_MAX)
                                                               : count_wide[6:0];
    assign quantity_sum    = (sum_wide > kcd_pkg::SUM_MAX) ? 22'(kcd_pkg::SUM_MAX)
                                                           : sum_wide[21:0];
    assign top_valid       = (count_reg != '0);
    assign top_key         = top_valid ? best_key_reg : '0;

    `KCD_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(DEPTH), "count over depth")
    `KCD_ASSERT_IMP(a_front_bound, clk, rst_n, 1'b1, front_reg <= AW'(DEPTH - 1), "front out of range")
    `KCD_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy && !done, "accept not busy")
    `KCD_ASSERT_NXT(a_done_single, clk, rst_n, done, !done && !busy, "done held over")
    `KCD_ASSERT_IMP(a_pop_in_scan, clk, rst_n, pop_rd_reg, state_reg == ST_SCAN, "pop data lost")
    `KCD_ASSERT_IMP(a_err_excl, clk, rst_n, done, !(full_error && empty_error), "both errors set")

endmodule
